>>> hdl/stk_pkg.sv
`timescale 1ns / 1ps

package stk_pkg;

    // sizes fixed by the word formats
    localparam int unsigned VALUE_W       = 32;
    localparam int unsigned FILL_W        = 5;
    localparam int unsigned DEPTH_DEFAULT = 16;

    // operation codes
    localparam logic [1:0] FUNC_PUSH    = 2'd0;
    localparam logic [1:0] FUNC_POP     = 2'd1;
    localparam logic [1:0] FUNC_REVERSE = 2'd2;
    localparam logic [1:0] FUNC_INSERT  = 2'd3;

    // status codes
    localparam logic [1:0] STATUS_DONE  = 2'd0;
    localparam logic [1:0] STATUS_FULL  = 2'd1;
    localparam logic [1:0] STATUS_EMPTY = 2'd2;

    typedef struct packed {
        logic [1:0]                func;
        logic signed [VALUE_W-1:0] value;
    } req_word_t;

    typedef struct packed {
        logic [1:0]                status;
        logic signed [VALUE_W-1:0] popped_value;
        logic [FILL_W-1:0]         fill_count;
    } rsp_word_t;

    // sequencer status towards the top level
    typedef struct packed {
        logic ready;
        logic done;
    } ctrl_stat_t;

endpackage

>>> hdl/stk_ram.sv
`timescale 1ns / 1ps

module stk_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr_a,
    input  logic [$clog2(DEPTH)-1:0] raddr_b,
    output logic [WIDTH-1:0]         rdata_a,
    output logic [WIDTH-1:0]         rdata_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    // one write port, two registered read ports
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_a <= mem[raddr_a];
        rdata_b <= mem[raddr_b];
    end

endmodule

>>> hdl/stk_ctrl.sv
`timescale 1ns / 1ps

module stk_ctrl #(
    parameter int unsigned DEPTH = stk_pkg::DEPTH_DEFAULT
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  req_take,
    input  stk_pkg::req_word_t    req,
    input  logic                  rsp_free,
    output stk_pkg::ctrl_stat_t   stat,
    output stk_pkg::rsp_word_t    result
);

    localparam int unsigned AW = $clog2(DEPTH);
    localparam int unsigned OW = $clog2(DEPTH + 1);
    localparam int unsigned VW = stk_pkg::VALUE_W;

    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_POP_RD   = 4'd1;
    localparam logic [3:0] S_POP_DATA = 4'd2;
    localparam logic [3:0] S_REV_RD   = 4'd3;
    localparam logic [3:0] S_REV_W1   = 4'd4;
    localparam logic [3:0] S_REV_W2   = 4'd5;
    localparam logic [3:0] S_INS_RD   = 4'd6;
    localparam logic [3:0] S_INS_CMP  = 4'd7;
    localparam logic [3:0] S_INS_PUT  = 4'd8;
    localparam logic [3:0] S_OUT      = 4'd9;

    logic [3:0]           state_reg, state_next;
    logic [OW-1:0]        occ_reg, occ_next;
    logic [AW-1:0]        ptr_a_reg, ptr_a_next;
    logic [AW-1:0]        ptr_b_reg, ptr_b_next;
    logic [1:0]           status_reg, status_next;
    logic signed [VW-1:0] popped_reg, popped_next;
    logic signed [VW-1:0] tmp_reg, tmp_next;
    logic signed [VW-1:0] ins_val_reg, ins_val_next;

    logic                 ram_we;
    logic [AW-1:0]        ram_waddr;
    logic [VW-1:0]        ram_wdata;
    logic [VW-1:0]        rdata_a;
    logic [VW-1:0]        rdata_b;

    logic                 is_full;
    logic                 is_empty;
    logic [AW-1:0]        occ_top;
    logic                 stored_greater;

    stk_ram #(
        .WIDTH (VW),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk     (clk),
        .we      (ram_we),
        .waddr   (ram_waddr),
        .wdata   (ram_wdata),
        .raddr_a (ptr_a_reg),
        .raddr_b (ptr_b_reg),
        .rdata_a (rdata_a),
        .rdata_b (rdata_b)
    );

    assign is_full  = (occ_reg == OW'(DEPTH));
    assign is_empty = (occ_reg == '0);
    assign occ_top  = AW'(occ_reg - OW'(1));

    // the shared compare: stored word just below the free slot vs new word
    assign stored_greater = ($signed(rdata_b) > ins_val_reg);

    // sequencer
    always_comb
    begin
        state_next   = state_reg;
        occ_next     = occ_reg;
        ptr_a_next   = ptr_a_reg;
        ptr_b_next   = ptr_b_reg;
        status_next  = status_reg;
        popped_next  = popped_reg;
        tmp_next     = tmp_reg;
        ins_val_next = ins_val_reg;
        ram_we       = 1'b0;
        ram_waddr    = ptr_a_reg;
        ram_wdata    = ins_val_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (req_take)
                begin
                    status_next  = stk_pkg::STATUS_DONE;
                    popped_next  = '0;
                    ins_val_next = req.value;
                    state_next   = S_OUT;
                    unique case (req.func)
                        stk_pkg::FUNC_PUSH:
                        begin
                            if (is_full)
                            begin
                                status_next = stk_pkg::STATUS_FULL;
                            end
                            else
                            begin
                                ram_we    = 1'b1;
                                ram_waddr = AW'(occ_reg);
                                ram_wdata = req.value;
                                occ_next  = occ_reg + OW'(1);
                            end
                        end
                        stk_pkg::FUNC_POP:
                        begin
                            if (is_empty)
                            begin
                                status_next = stk_pkg::STATUS_EMPTY;
                            end
                            else
                            begin
                                ptr_a_next = occ_top;
                                occ_next   = occ_reg - OW'(1);
                                state_next = S_POP_RD;
                            end
                        end
                        stk_pkg::FUNC_REVERSE:
                        begin
                            if (is_empty)
                            begin
                                status_next = stk_pkg::STATUS_EMPTY;
                            end
                            else if (occ_reg != OW'(1))
                            begin
                                ptr_a_next = '0;
                                ptr_b_next = occ_top;
                                state_next = S_REV_RD;
                            end
                        end
                        stk_pkg::FUNC_INSERT:
                        begin
                            if (is_full)
                            begin
                                status_next = stk_pkg::STATUS_FULL;
                            end
                            else
                            begin
                                occ_next = occ_reg + OW'(1);
                                if (is_empty)
                                begin
                                    ram_we    = 1'b1;
                                    ram_waddr = '0;
                                    ram_wdata = req.value;
                                end
                                else
                                begin
                                    ptr_a_next = AW'(occ_reg);
                                    ptr_b_next = occ_top;
                                    state_next = S_INS_RD;
                                end
                            end
                        end
                    endcase
                end
            end

            // pop: read address sampled, then data arrives
            S_POP_RD:
            begin
                state_next = S_POP_DATA;
            end
            S_POP_DATA:
            begin
                popped_next = rdata_a;
                state_next  = S_OUT;
            end

            // reverse: swap the outer pair, walk inwards
            S_REV_RD:
            begin
                state_next = S_REV_W1;
            end
            S_REV_W1:
            begin
                ram_we     = 1'b1;
                ram_waddr  = ptr_a_reg;
                ram_wdata  = rdata_b;
                tmp_next   = rdata_a;
                state_next = S_REV_W2;
            end
            S_REV_W2:
            begin
                ram_we     = 1'b1;
                ram_waddr  = ptr_b_reg;
                ram_wdata  = tmp_reg;
                ptr_a_next = ptr_a_reg + AW'(1);
                ptr_b_next = ptr_b_reg - AW'(1);
                if ((ptr_a_reg + AW'(1)) < (ptr_b_reg - AW'(1)))
                begin
                    state_next = S_REV_RD;
                end
                else
                begin
                    state_next = S_OUT;
                end
            end

            // sorted insert: shift greater words up one place at a time
            S_INS_RD:
            begin
                state_next = S_INS_CMP;
            end
            S_INS_CMP:
            begin
                ram_we = 1'b1;
                if (stored_greater)
                begin
                    ram_waddr  = ptr_a_reg;
                    ram_wdata  = rdata_b;
                    ptr_a_next = ptr_b_reg;
                    if (ptr_b_reg == '0)
                    begin
                        state_next = S_INS_PUT;
                    end
                    else
                    begin
                        ptr_b_next = ptr_b_reg - AW'(1);
                        state_next = S_INS_RD;
                    end
                end
                else
                begin
                    ram_waddr  = ptr_a_reg;
                    ram_wdata  = ins_val_reg;
                    state_next = S_OUT;
                end
            end
            S_INS_PUT:
            begin
                ram_we     = 1'b1;
                ram_waddr  = ptr_a_reg;
                ram_wdata  = ins_val_reg;
                state_next = S_OUT;
            end

            // hand the result over once the output register is free
            S_OUT:
            begin
                if (rsp_free)
                begin
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            occ_reg   <= '0;
            ptr_a_reg <= '0;
            ptr_b_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            occ_reg   <= occ_next;
            ptr_a_reg <= ptr_a_next;
            ptr_b_reg <= ptr_b_next;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        status_reg  <= status_next;
        popped_reg  <= popped_next;
        tmp_reg     <= tmp_next;
        ins_val_reg <= ins_val_next;
    end

    assign stat.ready          = (state_reg == S_IDLE);
    assign stat.done           = (state_reg == S_OUT) && rsp_free;
    assign result.status       = status_reg;
    assign result.popped_value = popped_reg;
    assign result.fill_count   = stk_pkg::FILL_W'(occ_reg);

endmodule

>>> hdl/stack_with_sorted_insert_core.sv
`timescale 1ns / 1ps

// Bounded LIFO stack of signed 32-bit words with push, pop, reverse and sorted
// insert, one operation per request word and one response word per request.
// The words live in a small two-read, one-write RAM that a sequencer walks one
// entry at a time, so the block takes a new request only when the previous one
// has finished its walk. Push, any refused operation, reverse of a single word and
// insert into an empty stack go straight to the response state. Pop passes a
// read state and a data state. Reverse reads each outer pair, then writes its
// two words back swapped, walking inwards. Sorted insert compares the word below
// the free slot, moves it up while greater, with an extra write state when the
// new word lands at the bottom. Throughput is set by the single RAM write port
// and the one signed comparator shared by every insert step. The response sits
// in an output register, so a stalled response only holds the next request off
// once that one is itself finished. Entries come out of reset undefined; only
// the fill count is cleared, so there is no clearing pass.
module stack_with_sorted_insert_core #(
    parameter int unsigned DEPTH = stk_pkg::DEPTH_DEFAULT
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               req_valid,
    output logic               req_ready,
    input  stk_pkg::req_word_t req,
    output logic               rsp_valid,
    input  logic               rsp_ready,
    output stk_pkg::rsp_word_t rsp
);

    stk_pkg::ctrl_stat_t stat;
    stk_pkg::rsp_word_t  result;
    logic                rsp_valid_reg;
    stk_pkg::rsp_word_t  rsp_reg;
    logic                rsp_free;
    logic                req_take;

    assign req_ready = stat.ready;
    assign req_take  = req_valid && stat.ready;
    assign rsp_free  = !rsp_valid_reg || rsp_ready;

    stk_ctrl #(
        .DEPTH (DEPTH)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .req_take (req_take),
        .req      (req),
        .rsp_free (rsp_free),
        .stat     (stat),
        .result   (result)
    );

    // response register valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else if (stat.done)
        begin
            rsp_valid_reg <= 1'b1;
        end
        else if (rsp_ready)
        begin
            rsp_valid_reg <= 1'b0;
        end
    end

    // response word
    always_ff @(posedge clk)
    begin
        if (stat.done)
        begin
            rsp_reg <= result;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule
